// ----- rtl/i2p_pkg.sv -----
// ============================================================================
// i2p_pkg
// Shared types, constants and helper functions of the infix to postfix core.
// ============================================================================
package i2p_pkg;

   localparam int DEFAULT_STACK_DEPTH = 32;
   localparam int FRONT_DEPTH         = 2;
   localparam int RSP_DEPTH           = 4;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_MUL   = 8'h2A;
   localparam logic [7:0] CHAR_DIV   = 8'h2F;
   localparam logic [7:0] CHAR_POW   = 8'h5E;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_NONE  = 8'h00;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef enum logic [2:0] {
      KIND_ALNUM,
      KIND_OPEN,
      KIND_CLOSE,
      KIND_OPER,
      KIND_END
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  ch;
      logic [1:0]  prec;
   } item_type;

   // Head of the front queue as seen by the stack engine.
   typedef struct packed {
      logic     valid;
      item_type item;
   } item_slot_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       valid;
      logic       last;
      logic       ovf;
   } result_type;

   function automatic logic [1:0] prec_of(input logic [7:0] c);
      logic [1:0] p;
      unique case (c) inside
         CHAR_PLUS, CHAR_MINUS: p = 2'd1;
         CHAR_MUL, CHAR_DIV:    p = 2'd2;
         CHAR_POW:              p = 2'd3;
         default:               p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

endpackage

// ----- rtl/i2p_front.sv -----
// ============================================================================
// i2p_front
// Accepts input items, classifies each character and holds them in a short
// queue in front of the stack engine.
// ============================================================================
module i2p_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic                   req_op,
   input  logic [7:0]             req_in_char,
   output i2p_pkg::item_slot_type head,
   input  logic                   take
);

   localparam int D  = i2p_pkg::FRONT_DEPTH;
   localparam int PW = (D > 1) ? $clog2(D) : 1;
   localparam int CW = $clog2(D + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(D - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(D);

   i2p_pkg::item_type q_ff [D];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   i2p_pkg::item_type new_item;
   logic wr_en, rd_en;

   always_comb begin
      new_item.ch   = req_in_char;
      new_item.prec = i2p_pkg::prec_of(req_in_char);
      if (req_op == i2p_pkg::OP_END) begin
         new_item.kind = i2p_pkg::KIND_END;
      end else if (i2p_pkg::is_alnum(req_in_char)) begin
         new_item.kind = i2p_pkg::KIND_ALNUM;
      end else if (req_in_char == i2p_pkg::CHAR_OPEN) begin
         new_item.kind = i2p_pkg::KIND_OPEN;
      end else if (req_in_char == i2p_pkg::CHAR_CLOSE) begin
         new_item.kind = i2p_pkg::KIND_CLOSE;
      end else begin
         new_item.kind = i2p_pkg::KIND_OPER;
      end
   end

   assign full       = (cnt_ff == CNT_FULL);
   assign wr_en      = push && !full;
   assign rd_en      = take && (cnt_ff != '0);
   assign head.valid = (cnt_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (!wr_en && rd_en) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- rtl/i2p_back.sv -----
// ============================================================================
// i2p_back
// Stack engine: unless the result queue is full, runs one step of the current
// item per cycle against the operator stack, emitting into the result queue.
// ============================================================================
module i2p_back #(
   parameter int STACK_DEPTH = i2p_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  i2p_pkg::item_slot_type head,
   output logic                   take,
   output logic                   rsp_wr,
   output i2p_pkg::result_type    rsp_data,
   input  logic                   rsp_full
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] CNT_ONE  = CW'(1);

   logic [7:0]    mem [STACK_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    rd_ff;
   logic [7:0]    wdata_ff;
   logic          byp_ff;
   logic          ovf_ff, ovf_in;

   logic [7:0]    top_ch;
   logic [1:0]    top_prec;
   logic          has, stack_full;
   logic          need_emit, want_push, want_pop, done, end_clear;
   logic [7:0]    emit_ch;
   logic          emit_valid, emit_last;
   logic          step_ok, do_write, do_pop;
   logic [CW-1:0] raddr_full;
   logic [AW-1:0] raddr;

   // The top entry is read every cycle at the next count; a push in the same
   // cycle lands at that very address, so the pushed byte is forwarded.
   assign top_ch     = byp_ff ? wdata_ff : rd_ff;
   assign top_prec   = i2p_pkg::prec_of(top_ch);
   assign has        = (count_ff != '0);
   assign stack_full = (count_ff == CNT_FULL);

   always_comb begin
      need_emit  = 1'b0;
      want_push  = 1'b0;
      want_pop   = 1'b0;
      done       = 1'b0;
      end_clear  = 1'b0;
      emit_ch    = top_ch;
      emit_valid = 1'b1;
      emit_last  = 1'b0;
      unique case (head.item.kind)
         i2p_pkg::KIND_ALNUM: begin
            need_emit = 1'b1;
            emit_ch   = head.item.ch;
            done      = 1'b1;
         end
         i2p_pkg::KIND_OPEN: begin
            want_push = 1'b1;
            done      = 1'b1;
         end
         i2p_pkg::KIND_CLOSE: begin
            if (has && (top_ch != i2p_pkg::CHAR_OPEN)) begin
               need_emit = 1'b1;
               want_pop  = 1'b1;
            end else begin
               want_pop = has;
               done     = 1'b1;
            end
         end
         i2p_pkg::KIND_OPER: begin
            if (has && (head.item.prec <= top_prec)) begin
               need_emit = 1'b1;
               want_pop  = 1'b1;
            end else begin
               want_push = 1'b1;
               done      = 1'b1;
            end
         end
         i2p_pkg::KIND_END: begin
            need_emit = 1'b1;
            if (!has) begin
               emit_ch    = i2p_pkg::CHAR_NONE;
               emit_valid = 1'b0;
               emit_last  = 1'b1;
               done       = 1'b1;
               end_clear  = 1'b1;
            end else begin
               want_pop  = 1'b1;
               emit_last = (count_ff == CNT_ONE);
               done      = emit_last;
               end_clear = emit_last;
            end
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   assign step_ok  = head.valid && !(need_emit && rsp_full);
   assign take     = step_ok && done;
   assign do_write = step_ok && want_push && !stack_full;
   assign do_pop   = step_ok && want_pop;

   assign rsp_wr         = step_ok && need_emit;
   assign rsp_data.ch    = emit_ch;
   assign rsp_data.valid = emit_valid;
   assign rsp_data.last  = emit_last;
   assign rsp_data.ovf   = ovf_ff;

   always_comb begin
      count_in = count_ff;
      if (do_write) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop) begin
         count_in = count_ff - CW'(1);
      end
      ovf_in = ovf_ff;
      if (step_ok && want_push && stack_full) begin
         ovf_in = 1'b1;
      end else if (step_ok && end_clear) begin
         ovf_in = 1'b0;
      end
      raddr_full = count_in - CW'(1);
      raddr      = raddr_full[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         byp_ff   <= do_write;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff    <= mem[raddr];
      wdata_ff <= head.item.ch;
      if (do_write) begin
         mem[count_ff[AW-1:0]] <= head.item.ch;
      end
   end

endmodule

// ----- rtl/i2p_rsp_fifo.sv -----
// ============================================================================
// i2p_rsp_fifo
// Result queue between the stack engine and the result ports.
// ============================================================================
module i2p_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr,
   input  i2p_pkg::result_type wr_data,
   output logic                wr_full,
   output logic                empty,
   input  logic                pop,
   output i2p_pkg::result_type head
);

   localparam int D  = i2p_pkg::RSP_DEPTH;
   localparam int PW = (D > 1) ? $clog2(D) : 1;
   localparam int CW = $clog2(D + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(D - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(D);

   i2p_pkg::result_type q_ff [D];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic wr_en, rd_en;

   assign wr_full = (cnt_ff == CNT_FULL);
   assign empty   = (cnt_ff == '0);
   assign wr_en   = wr && !wr_full;
   assign rd_en   = pop && !empty;
   assign head    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (!wr_en && rd_en) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/infix_to_postfix_converter_core.sv -----
// ============================================================================
// infix_to_postfix_converter_core
// Shunting-yard infix to postfix converter with a bounded operator stack.
// ============================================================================
//
//   Channel   Ports                                         Transfer when
//   input     push, full, req_op, req_in_char               push && !full
//   result    empty, pop, rsp_out_char, rsp_char_valid,     pop && !empty
//             rsp_last, rsp_overflow
//
// The stack engine works in steps. A letter, digit or end item takes one step
// per result it emits; any other character takes one step per entry it pops
// and emits plus one last step that pushes it or drops '('. Each item is
// registered in the front queue before the engine sees it, and each result in
// the result queue before the ports. A full result queue holds the engine.
// Synchronous reset empties both queues and the stack, with no clearing pass.
//
module infix_to_postfix_converter_core #(
   parameter int STACK_DEPTH = i2p_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_op,
   input  logic [7:0] req_in_char,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_last,
   output logic       rsp_overflow
);

   i2p_pkg::item_slot_type head;
   logic                   take;
   logic                   rsp_wr;
   logic                   rsp_full;
   i2p_pkg::result_type    rsp_wr_data;
   i2p_pkg::result_type    rsp_head;

   i2p_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_op      (req_op),
      .req_in_char (req_in_char),
      .head        (head),
      .take        (take)
   );

   i2p_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .take     (take),
      .rsp_wr   (rsp_wr),
      .rsp_data (rsp_wr_data),
      .rsp_full (rsp_full)
   );

   i2p_rsp_fifo u_rsp (
      .clock   (clock),
      .reset   (reset),
      .wr      (rsp_wr),
      .wr_data (rsp_wr_data),
      .wr_full (rsp_full),
      .empty   (empty),
      .pop     (pop),
      .head    (rsp_head)
   );

   assign rsp_out_char   = rsp_head.ch;
   assign rsp_char_valid = rsp_head.valid;
   assign rsp_last       = rsp_head.last;
   assign rsp_overflow   = rsp_head.ovf;

endmodule

// ----- rtl/i2p_checker.sv -----
// ============================================================================
// i2p_checker
// Port-level checks of the infix to postfix core, attached by bind.
// ============================================================================
module i2p_checker (
   input logic       clock,
   input logic       reset,
   input logic       push,
   input logic       full,
   input logic       req_op,
   input logic [7:0] req_in_char,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_out_char,
   input logic       rsp_char_valid,
   input logic       rsp_last,
   input logic       rsp_overflow
);

   // Both queues come out of reset empty.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // A result without a character is only the end marker of an empty stack.
   a_marker : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_char_valid) |-> (rsp_last && (rsp_out_char == 8'h00)))
      else $error("empty marker malformed");

   // A waiting result that is not taken stays unchanged.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_char) &&
         $stable(rsp_char_valid) && $stable(rsp_last) && $stable(rsp_overflow)))
      else $error("stalled result changed");

   // Just after reset, no result appears unless an input item is taken first.
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      ($past(reset) && empty && !(push && !full)) |=> empty)
      else $error("result appeared without input");

endmodule

bind infix_to_postfix_converter_core i2p_checker u_i2p_checker (.*);
